// ----- src/hnm_pkg.sv -----
package hnm_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_ROUGHNESS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [11:0] ROUGHNESS_RST = 12'd256;
  localparam logic [10:0] FRAME_SIZE_RST = 11'd1024;

  localparam logic [7:0] BLUE_VALUE = 8'd255;
  localparam logic [6:0] CHAN_SCALE = 7'd127;
  localparam logic [23:0] CHAN_BASE = 24'd8323072;

  typedef enum logic {
    KIND_WRITE,
    KIND_COMPUTE
  } hnm_kind_e;

  typedef struct packed {
    logic       req_type;
    logic [9:0] col;
    logic [9:0] row;
    logic [7:0] height_value;
  } hnm_req_t;

  typedef struct packed {
    logic [9:0] out_col;
    logic [9:0] out_row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hnm_res_t;

  typedef struct packed {
    hnm_kind_e  kind;
    logic [9:0] col;
    logic [9:0] row;
    logic [7:0] hv;
  } hnm_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_GRAD,
    ST_NORM,
    ST_DINIT,
    ST_DIV,
    ST_SQRT,
    ST_CHAN
  } hnm_state_e;

endpackage

// ----- src/hnm_front.sv -----
module hnm_front import hnm_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int unsigned AW = (MAX_WIDTH * MAX_HEIGHT > 1) ?
                               $clog2(MAX_WIDTH * MAX_HEIGHT) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  hnm_req_t              req_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic [11:0]           rough_o,
  output logic                  q_valid_o,
  output hnm_cmd_t              q_cmd_o,
  output logic [3:0][AW-1:0]    q_addr_o,
  input  logic                  q_pop_i
);

  localparam int unsigned SW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SH = $clog2(MAX_HEIGHT + 1);

  logic [11:0] rough_q;
  logic [10:0] fw_q, fh_q;

  logic [SW-1:0] fw, c, cl, cr;
  logic [SH-1:0] fh, r, ru, rd;
  hnm_cmd_t          cmd;
  logic [3:0][AW-1:0] addr;
  logic              push;

  hnm_cmd_t           cmd_mem_q [2];
  logic [3:0][AW-1:0] addr_mem_q [2];
  logic               wp_q, rp_q;
  logic [1:0]         cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rough_q <= ROUGHNESS_RST;
      fw_q    <= FRAME_SIZE_RST;
      fh_q    <= FRAME_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROUGHNESS:    rough_q <= cfg_wdata_i;
        REG_FRAME_WIDTH:  fw_q    <= cfg_wdata_i[10:0];
        REG_FRAME_HEIGHT: fh_q    <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fw_q == '0) fw = SW'(1);
    else if (32'(fw_q) > 32'(MAX_WIDTH)) fw = SW'(MAX_WIDTH);
    else fw = SW'(fw_q);
    if (fh_q == '0) fh = SH'(1);
    else if (32'(fh_q) > 32'(MAX_HEIGHT)) fh = SH'(MAX_HEIGHT);
    else fh = SH'(fh_q);

    c  = (32'(req_i.col) < 32'(fw)) ? SW'(req_i.col) : fw - SW'(1);
    r  = (32'(req_i.row) < 32'(fh)) ? SH'(req_i.row) : fh - SH'(1);
    cl = (c == '0) ? fw - SW'(1) : c - SW'(1);
    cr = (32'(c) + 32'd1 >= 32'(fw)) ? '0 : c + SW'(1);
    ru = (r == '0) ? fh - SH'(1) : r - SH'(1);
    rd = (32'(r) + 32'd1 >= 32'(fh)) ? '0 : r + SH'(1);

    cmd.kind = req_i.req_type ? KIND_COMPUTE : KIND_WRITE;
    cmd.col  = req_i.col;
    cmd.row  = req_i.row;
    cmd.hv   = req_i.height_value;

    addr[1] = AW'(32'(r) * 32'(MAX_WIDTH) + 32'(cr));
    addr[2] = AW'(32'(ru) * 32'(MAX_WIDTH) + 32'(c));
    addr[3] = AW'(32'(rd) * 32'(MAX_WIDTH) + 32'(c));
    if (req_i.req_type) begin
      addr[0] = AW'(32'(r) * 32'(MAX_WIDTH) + 32'(cl));
    end else begin
      addr[0] = AW'(32'(req_i.row) * 32'(MAX_WIDTH) + 32'(req_i.col));
    end

    push = start_i && !busy_o &&
           (req_i.req_type ||
            (32'(req_i.col) < 32'(MAX_WIDTH) && 32'(req_i.row) < 32'(MAX_HEIGHT)));
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_mem_q[wp_q]  <= cmd;
      addr_mem_q[wp_q] <= addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      if (push && !q_pop_i) cnt_q <= cnt_q + 2'd1;
      else if (!push && q_pop_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  assign busy_o    = (cnt_q == 2'd2);
  assign q_valid_o = (cnt_q != '0);
  assign q_cmd_o   = cmd_mem_q[rp_q];
  assign q_addr_o  = addr_mem_q[rp_q];
  assign rough_o   = rough_q;

endmodule

// ----- src/hnm_back.sv -----
module hnm_back import hnm_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int unsigned AW = (MAX_WIDTH * MAX_HEIGHT > 1) ?
                               $clog2(MAX_WIDTH * MAX_HEIGHT) : 1,
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [11:0]        rough_i,
  input  logic               q_valid_i,
  input  hnm_cmd_t           q_cmd_i,
  input  logic [3:0][AW-1:0] q_addr_i,
  output logic               q_pop_o,
  output logic               valid_o,
  output hnm_res_t           res_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;
  logic       mem_we;
  logic [AW-1:0] rd_addr;

  hnm_state_e state_q, state_d;

  hnm_cmd_t           cmd_q;
  logic [3:0][AW-1:0] addr_q;
  logic [5:0]         cnt_q;
  logic [3:0][7:0]    h_q;
  logic [1:0]         sgn_q;
  logic [1:0][11:0]   mag_q;
  logic [1:0][23:0]   sq_q;
  logic [25:0]        norm_q;
  logic [26:0]        rem_q;
  logic [31:0]        quo_q;
  logic [31:0]        x_q, res_q;
  logic [15:0]        q_q;
  logic               ch_q;
  logic [7:0]         red_q;
  logic               valid_q;
  hnm_res_t           out_q;

  logic [26:0] rem_sh;
  logic [31:0] quo_nxt;
  logic [26:0] rem_nxt;
  logic [31:0] bitv, trial, x_nxt, res_nxt;
  logic [7:0]  dmag0, dmag1;
  logic [19:0] prod0, prod1;
  logic [22:0] p;
  logic [23:0] pos_v;
  logic [7:0]  chan;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[q_addr_i[0]] <= q_cmd_i.hv;
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    mem_we  = 1'b0;
    rd_addr = addr_q[cnt_q[1:0]];
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_cmd_i.kind == KIND_WRITE) mem_we = 1'b1;
          else state_d = ST_READ;
        end
      end
      ST_READ:  if (cnt_q == 6'd4) state_d = ST_GRAD;
      ST_GRAD:  state_d = ST_NORM;
      ST_NORM:  state_d = ST_DINIT;
      ST_DINIT: state_d = ST_DIV;
      ST_DIV:   if (cnt_q == 6'd31) state_d = ST_SQRT;
      ST_SQRT:  if (cnt_q == 6'd15) state_d = ST_CHAN;
      ST_CHAN:  state_d = ch_q ? ST_IDLE : ST_DINIT;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    dmag0 = (h_q[0] < h_q[1]) ? h_q[1] - h_q[0] : h_q[0] - h_q[1];
    dmag1 = (h_q[2] < h_q[3]) ? h_q[3] - h_q[2] : h_q[2] - h_q[3];
    prod0 = 20'(dmag0) * 20'(rough_i);
    prod1 = 20'(dmag1) * 20'(rough_i);

    rem_sh = {rem_q[25:0], 1'b0};
    if (rem_sh >= 27'(norm_q)) begin
      rem_nxt = rem_sh - 27'(norm_q);
      quo_nxt = {quo_q[30:0], 1'b1};
    end else begin
      rem_nxt = rem_sh;
      quo_nxt = {quo_q[30:0], 1'b0};
    end

    bitv  = 32'h4000_0000 >> {cnt_q[3:0], 1'b0};
    trial = res_q + bitv;
    if (x_q >= trial) begin
      x_nxt   = x_q - trial;
      res_nxt = (res_q >> 1) + bitv;
    end else begin
      x_nxt   = x_q;
      res_nxt = res_q >> 1;
    end

    p     = 23'(q_q) * 23'(CHAN_SCALE);
    pos_v = CHAN_BASE - 24'(p);
    if (sgn_q[ch_q]) chan = 8'(CHAN_SCALE) + 8'(p[22:16]);
    else chan = pos_v[23:16];
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        cmd_q  <= q_cmd_i;
        addr_q <= q_addr_i;
        cnt_q  <= '0;
      end
      ST_READ: begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q != '0) h_q[cnt_q[1:0] - 2'd1] <= rdata_q;
      end
      ST_GRAD: begin
        sgn_q[0] <= (h_q[0] < h_q[1]);
        sgn_q[1] <= (h_q[2] < h_q[3]);
        mag_q[0] <= prod0[19:8];
        mag_q[1] <= prod1[19:8];
      end
      ST_NORM: begin
        sq_q[0] <= 24'(mag_q[0]) * 24'(mag_q[0]);
        sq_q[1] <= 24'(mag_q[1]) * 24'(mag_q[1]);
        ch_q    <= 1'b0;
      end
      ST_DINIT: begin
        norm_q <= 26'(sq_q[0]) + 26'(sq_q[1]) + 26'd1;
        rem_q  <= 27'(sq_q[ch_q]);
        quo_q  <= '0;
        cnt_q  <= '0;
      end
      ST_DIV: begin
        rem_q <= rem_nxt;
        quo_q <= quo_nxt;
        if (cnt_q == 6'd31) begin
          x_q   <= quo_nxt;
          res_q <= '0;
          cnt_q <= '0;
        end else begin
          cnt_q <= cnt_q + 6'd1;
        end
      end
      ST_SQRT: begin
        x_q   <= x_nxt;
        res_q <= res_nxt;
        cnt_q <= cnt_q + 6'd1;
        q_q   <= res_nxt[15:0];
      end
      ST_CHAN: begin
        red_q <= chan;
        ch_q  <= 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= (state_q == ST_CHAN) && ch_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CHAN && ch_q) begin
      out_q.out_col <= cmd_q.col;
      out_q.out_row <= cmd_q.row;
      out_q.red     <= red_q;
      out_q.green   <= chan;
      out_q.blue    <= BLUE_VALUE;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = out_q;

endmodule

// ----- src/height_to_normal_map.sv -----
// A write request is held in the request queue and reaches the frame store once the back
// end is idle; writes sustain one per cycle while the back end stays idle. The back end
// handles one compute request at a time, while the queue holds up to two more; its result
// is strobed after a shared restoring divider (32 steps) and a digit-by-digit square root
// (16 steps) run once for each of the red and green channels, after 4 store reads.
// Reset clears the control state and sets the registers to their defaults; the frame
// store holds no defined content until written. The receiver cannot stall a result.
module height_to_normal_map import hnm_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  hnm_req_t              req_i,
  output logic                  valid_o,
  output hnm_res_t              res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW = (MAX_WIDTH * MAX_HEIGHT > 1) ?
                               $clog2(MAX_WIDTH * MAX_HEIGHT) : 1;

  logic [11:0]        rough;
  logic               q_valid, q_pop;
  hnm_cmd_t           q_cmd;
  logic [3:0][AW-1:0] q_addr;

  hnm_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .rough_o    (rough),
    .q_valid_o  (q_valid),
    .q_cmd_o    (q_cmd),
    .q_addr_o   (q_addr),
    .q_pop_i    (q_pop)
  );

  hnm_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rough_i  (rough),
    .q_valid_i(q_valid),
    .q_cmd_i  (q_cmd),
    .q_addr_i (q_addr),
    .q_pop_o  (q_pop),
    .valid_o  (valid_o),
    .res_o    (res_o)
  );

endmodule
